// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks shared by the RTL, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== sv/fir_pkg.sv =====
// ----------------------------------------------------------------------------
// fir_pkg
// Shared widths, codes and control types of the FIR filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fir_pkg;

	localparam int MAX_TAPS_DEF = 2048;
	localparam int SAMP_W       = 24;
	localparam int COEF_W       = 24;
	localparam int TAPCNT_W     = 12;
	localparam int CIDX_W       = 11;
	localparam int PROD_W       = SAMP_W + COEF_W;
	localparam int FRAC_W       = 23;
	localparam int IN_DATA_W    = 64;
	localparam int OUT_DATA_W   = 48;

	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_COEF   = 1'b1;

	typedef struct packed {
		logic clear;
		logic vld;
		logic last;
	} mac_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/fir_mac.sv =====
// ----------------------------------------------------------------------------
// fir_mac
// Multiply-accumulate pipeline with rounding and saturation of the sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fir_mac #(
	parameter int ACC_W = 60
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  fir_pkg::mac_ctrl_t                 ctl,
	input  wire signed [fir_pkg::COEF_W-1:0]   coef,
	input  wire signed [fir_pkg::SAMP_W-1:0]   samp,
	output logic signed [fir_pkg::SAMP_W-1:0]  filt,
	output logic                               done
);
	import fir_pkg::*;

	localparam int ROUND_HALF = 1 << (FRAC_W - 1);
	localparam int SAT_HI     = (1 << (SAMP_W - 1)) - 1;
	localparam int SAT_LO     = -(1 << (SAMP_W - 1));

	logic signed [PROD_W-1:0] prod_s2;
	logic                     vld_s2;
	logic                     last_s2;
	logic                     last_s3;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W:0]    rnd;
	logic signed [ACC_W:0]    shr;
	logic signed [SAMP_W-1:0] sat;

	always_comb begin
		rnd = (ACC_W + 1)'(acc_q) + (ACC_W + 1)'(ROUND_HALF);
		shr = rnd >>> FRAC_W;
		if (shr > SAT_HI) begin
			sat = SAMP_W'(SAT_HI);
		end else if (shr < SAT_LO) begin
			sat = SAMP_W'(SAT_LO);
		end else begin
			sat = shr[SAMP_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= coef * samp;
		if (last_s3) begin
			filt <= sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
			last_s3 <= 1'b0;
			done    <= 1'b0;
			acc_q   <= '0;
		end else begin
			vld_s2  <= ctl.vld;
			last_s2 <= ctl.last;
			last_s3 <= last_s2;
			done    <= last_s3;
			if (ctl.clear) begin
				acc_q <= '0;
			end else if (vld_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/fir_filter_with_delayed_dry.sv =====
// ----------------------------------------------------------------------------
// fir_filter_with_delayed_dry
// Direct-form FIR filter over a circular history memory, with center tap out.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    s_tdata, s_tuser (mode)
//  m_*      out  m_tvalid / m_tready    m_tdata
//  cfg_*    in   cfg_valid / cfg_ready  cfg_data (tap_count)
//
//  Sample transaction: min(tap_count, MAX_TAPS) taps summed to a result (one
//  MAC per tap, one shared read port on each of the history and coefficient
//  memories).
//  Coefficient transaction: no result.
//  After reset the history memory is cleared, with s_tready low.
//  A pending result in the output register does not block the next input;
//  a stalled output holds the following result at the end of its sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fir_filter_with_delayed_dry #(
	parameter int MAX_TAPS = fir_pkg::MAX_TAPS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// sample_in[23:0], coef_index[34:24], coef_value[58:35], zero pad
	input  wire  [fir_pkg::IN_DATA_W-1:0]       s_tdata,
	// mode[0]
	input  wire                                 s_tuser,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// filtered[23:0], delayed_dry[47:24]
	output logic [fir_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [fir_pkg::TAPCNT_W-1:0]        cfg_data
);
	import fir_pkg::*;

	localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CW    = $clog2(MAX_TAPS + 1);
	localparam int ACC_W = PROD_W + AW + 1;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DRY   = 3'd2;
	localparam logic [2:0] ST_RUN   = 3'd3;
	localparam logic [2:0] ST_WAIT  = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

	logic signed [SAMP_W-1:0] hist_mem [MAX_TAPS];
	logic signed [COEF_W-1:0] coef_mem [MAX_TAPS];

	logic [2:0]               state_q;
	logic [TAPCNT_W-1:0]      tap_cnt_q;
	logic [CW-1:0]            taps_q;
	logic [AW-1:0]            newest_q;
	logic [AW-1:0]            clr_q;
	logic [AW-1:0]            k_q;
	logic [AW-1:0]            pos_q;
	logic                     dry_s1;
	logic signed [SAMP_W-1:0] dry_q;
	logic                     m_tvalid_q;
	logic [OUT_DATA_W-1:0]    m_tdata_q;
	mac_ctrl_t                ctl_s1;
	mac_ctrl_t                ctl;
	logic signed [SAMP_W-1:0] hist_rd_s1;
	logic signed [COEF_W-1:0] coef_rd_s1;

	logic                     in_acc;
	logic                     in_mode;
	logic signed [SAMP_W-1:0] in_samp;
	logic [CIDX_W-1:0]        in_cidx;
	logic signed [COEF_W-1:0] in_coef;
	logic [31:0]              cidx_ext;
	logic [31:0]              tap_ext;
	logic [CW-1:0]            taps_clamp;
	logic [AW-1:0]            new_pos;
	logic [AW:0]              dry_sum;
	logic [AW-1:0]            dry_addr;
	logic                     k_last;
	logic                     hist_we;
	logic [AW-1:0]            hist_wa;
	logic signed [SAMP_W-1:0] hist_wd;
	logic [AW-1:0]            hist_ra;
	logic                     coef_we;
	logic                     out_load;
	logic signed [SAMP_W-1:0] mac_filt;
	logic                     mac_done;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign in_acc  = s_tvalid && s_tready;
	assign in_mode = s_tuser;
	assign in_samp = s_tdata[SAMP_W-1:0];
	assign in_cidx = s_tdata[SAMP_W+CIDX_W-1:SAMP_W];
	assign in_coef = s_tdata[SAMP_W+CIDX_W+COEF_W-1:SAMP_W+CIDX_W];

	assign cidx_ext = 32'(in_cidx);
	assign tap_ext  = 32'(tap_cnt_q);

	always_comb begin
		if (tap_ext > 32'(MAX_TAPS)) begin
			taps_clamp = CW'(MAX_TAPS);
		end else begin
			taps_clamp = tap_ext[CW-1:0];
		end
		new_pos = (newest_q == '0) ? LAST_ADDR : newest_q - 1'b1;
		dry_sum = {1'b0, newest_q} + (AW + 1)'(taps_q >> 1);
		if (dry_sum >= (AW + 1)'(MAX_TAPS)) begin
			dry_addr = AW'(dry_sum - (AW + 1)'(MAX_TAPS));
		end else begin
			dry_addr = dry_sum[AW-1:0];
		end
		k_last = (({1'b0, k_q} + 1'b1) == (AW + 1)'(taps_q));
	end

	always_comb begin
		hist_we = 1'b0;
		hist_wa = new_pos;
		hist_wd = in_samp;
		hist_ra = pos_q;
		coef_we = 1'b0;
		ctl     = '0;
		case (state_q)
			ST_CLEAR: begin
				hist_we = 1'b1;
				hist_wa = clr_q;
				hist_wd = '0;
			end
			ST_IDLE: begin
				if (in_acc && in_mode == MODE_SAMPLE) begin
					hist_we = 1'b1;
				end
				if (in_acc && in_mode == MODE_COEF && cidx_ext < 32'(MAX_TAPS)) begin
					coef_we = 1'b1;
				end
			end
			ST_DRY: begin
				hist_ra   = dry_addr;
				ctl.clear = 1'b1;
				ctl.last  = (taps_q == '0);
			end
			ST_RUN: begin
				ctl.vld  = 1'b1;
				ctl.last = k_last;
			end
			default: begin
			end
		endcase
	end

	assign out_load = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_wa] <= hist_wd;
		end
		hist_rd_s1 <= hist_mem[hist_ra];
		if (coef_we) begin
			coef_mem[cidx_ext[AW-1:0]] <= in_coef;
		end
		coef_rd_s1 <= coef_mem[k_q];
		if (dry_s1) begin
			dry_q <= hist_rd_s1;
		end
		if (out_load) begin
			m_tdata_q <= {dry_q, mac_filt};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			tap_cnt_q  <= TAPCNT_W'(1);
			taps_q     <= '0;
			newest_q   <= '0;
			clr_q      <= '0;
			k_q        <= '0;
			pos_q      <= '0;
			dry_s1     <= 1'b0;
			ctl_s1     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tap_cnt_q <= cfg_data;
			end
			ctl_s1 <= ctl;
			dry_s1 <= (state_q == ST_DRY);
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc && in_mode == MODE_SAMPLE) begin
						newest_q <= new_pos;
						taps_q   <= taps_clamp;
						state_q  <= ST_DRY;
					end
				end
				ST_DRY: begin
					k_q     <= '0;
					pos_q   <= newest_q;
					state_q <= (taps_q == '0) ? ST_WAIT : ST_RUN;
				end
				ST_RUN: begin
					k_q   <= k_q + 1'b1;
					pos_q <= (pos_q == LAST_ADDR) ? '0 : pos_q + 1'b1;
					if (k_last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (mac_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	fir_mac #(
		.ACC_W (ACC_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s1),
		.coef   (coef_rd_s1),
		.samp   (hist_rd_s1),
		.filt   (mac_filt),
		.done   (mac_done)
	);

	`ASSERT_NEVER(a_no_accept_in_clear, state_q == ST_CLEAR && s_tready, "input ready during clear")
	`ASSERT_CLK(a_done_in_wait, mac_done |-> state_q == ST_WAIT, "sum done outside wait")
	`ASSERT_CLK(a_tap_in_range, state_q == ST_RUN |-> (AW + 1)'(k_q) < (AW + 1)'(taps_q), "tap index past tap count")
	`ASSERT_CLK(a_out_from_fin, $rose(m_tvalid) |-> $past(state_q == ST_FIN), "result without finished sum")

endmodule

`default_nettype wire
